// ===== src/range_max_segment_tree_top_macros.svh =====
// Assertion helpers used by the tree back end.
`ifndef RANGE_MAX_SEGMENT_TREE_TOP_MACROS_SVH
`define RANGE_MAX_SEGMENT_TREE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RMST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmst assertion failed");

// Next-cycle implication, checked outside reset.
`define RMST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmst assertion failed");

`endif

// ===== src/rmst_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rmst_pkg;

  localparam int unsigned LEAVES    = 1024;
  localparam int unsigned SPAN      = 1024;
  localparam int unsigned NODES     = 2 * SPAN;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned RANGE_W   = 11;
  localparam int unsigned NODE_W    = 11;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned DATA_W    = 32;

  localparam logic signed [DATA_W-1:0] LOWEST_VALUE = -32'sd2147483647;
  localparam logic [NODE_W-1:0]        NODE_LAST    = NODE_W'(NODES - 1);
  localparam logic [NODE_W-1:0]        NODE_ROOT    = NODE_W'(1);

  // Item classes decided by the front end
  typedef enum logic [1:0] {
    KIND_UPDATE,
    KIND_QUERY,
    KIND_EMPTY
  } kind_t;

  // Queued work item
  typedef struct packed {
    kind_t                     kind;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
    logic [IDX_W-1:0]          l;
    logic [IDX_W-1:0]          r;
  } entry_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_RD,
    ST_U_WR,
    ST_Q_TEST,
    ST_Q_L,
    ST_Q_R
  } st_t;

endpackage
`default_nettype wire

// ===== src/range_max_segment_tree_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Range-maximum segment tree over 1024 leaves, one 2048 x 32 tree memory.
// Update: writes the leaf, then per level reads the sibling and writes the parent max, over 10 levels.
// Query: walks l and r up the tree level by level, reading each boundary node it takes in; done then pulses.
// Empty range: done pulses without any tree read. Results cannot be stalled.
// After rst the memory is cleared one node a cycle: busy stays high until all 2048 nodes are cleared.
module range_max_segment_tree_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               opcode,
  input  wire logic [rmst_pkg::POS_W-1:0]         position,
  input  wire logic signed [rmst_pkg::DATA_W-1:0] new_value,
  input  wire logic [rmst_pkg::RANGE_W-1:0]       range_start,
  input  wire logic [rmst_pkg::RANGE_W-1:0]       range_end,
  output logic                                    done,
  output logic signed [rmst_pkg::DATA_W-1:0]      range_maximum
);
  import rmst_pkg::*;

  entry_t    push_entry;
  entry_t    head;
  q_status_t status;
  logic      push;
  logic      pop;
  logic      clearing;

  rmst_front u_front (
    .start       (start),
    .opcode      (opcode),
    .position    (position),
    .new_value   (new_value),
    .range_start (range_start),
    .range_end   (range_end),
    .q_full      (status.full),
    .clearing    (clearing),
    .busy        (busy),
    .push        (push),
    .entry       (push_entry)
  );

  rmst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (status)
  );

  rmst_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .status        (status),
    .pop           (pop),
    .clearing      (clearing),
    .done          (done),
    .range_maximum (range_maximum)
  );

endmodule
`default_nettype wire

// ===== src/rmst_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rmst_front (
  input  wire logic                               start,
  input  wire logic                               opcode,
  input  wire logic [rmst_pkg::POS_W-1:0]         position,
  input  wire logic signed [rmst_pkg::DATA_W-1:0] new_value,
  input  wire logic [rmst_pkg::RANGE_W-1:0]       range_start,
  input  wire logic [rmst_pkg::RANGE_W-1:0]       range_end,
  input  wire logic                               q_full,
  input  wire logic                               clearing,
  output logic                                    busy,
  output logic                                    push,
  output rmst_pkg::entry_t                        entry
);
  import rmst_pkg::*;

  logic [RANGE_W-1:0] hi_clamp;

  // Clamp the range end to the leaf count
  assign hi_clamp = (range_end > RANGE_W'(LEAVES)) ? RANGE_W'(LEAVES) : range_end;

  assign busy = q_full | clearing;
  assign push = start & ~busy;

  // Classify and map leaf indices onto tree nodes
  always_comb begin
    entry.position = position;
    entry.value    = new_value;
    entry.l        = IDX_W'(range_start) + IDX_W'(SPAN);
    entry.r        = IDX_W'(hi_clamp) + IDX_W'(SPAN);
    if (!opcode) begin
      entry.kind = KIND_UPDATE;
    end else if (range_start >= hi_clamp) begin
      entry.kind = KIND_EMPTY;
    end else begin
      entry.kind = KIND_QUERY;
    end
  end

endmodule
`default_nettype wire

// ===== src/rmst_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rmst_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire rmst_pkg::entry_t push_entry,
  input  wire logic             pop,
  output rmst_pkg::entry_t      head,
  output rmst_pkg::q_status_t   status
);
  import rmst_pkg::*;

  entry_t      slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign head         = slots[rd_ptr];
  assign status.valid = (count != 2'd0);
  assign status.full  = (count == 2'd2);

  // Pointer and fill tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule
`default_nettype wire

// ===== src/rmst_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "range_max_segment_tree_top_macros.svh"
module rmst_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire rmst_pkg::entry_t              head,
  input  wire rmst_pkg::q_status_t           status,
  output logic                               pop,
  output logic                               clearing,
  output logic                               done,
  output logic signed [rmst_pkg::DATA_W-1:0] range_maximum
);
  import rmst_pkg::*;

  logic signed [DATA_W-1:0] mem [NODES];
  logic signed [DATA_W-1:0] rd_data;

  st_t                      st, st_next;
  logic [NODE_W-1:0]        clr_cnt, clr_cnt_next;
  logic [NODE_W-1:0]        k, k_next;
  logic signed [DATA_W-1:0] cur, cur_next;
  logic [IDX_W-1:0]         l, l_next;
  logic [IDX_W-1:0]         r, r_next;
  logic signed [DATA_W-1:0] best, best_next;
  logic                     done_next;
  logic signed [DATA_W-1:0] range_maximum_next;

  logic                     wr_en;
  logic [NODE_W-1:0]        wr_addr;
  logic signed [DATA_W-1:0] wr_data;
  logic                     rd_en;
  logic [NODE_W-1:0]        rd_addr;
  logic [IDX_W-1:0]         r_dec;

  assign clearing = (st == ST_CLEAR);
  assign r_dec    = r - IDX_W'(1);

  // Tree memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= ST_CLEAR;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      st      <= st_next;
      clr_cnt <= clr_cnt_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    k             <= k_next;
    cur           <= cur_next;
    l             <= l_next;
    r             <= r_next;
    best          <= best_next;
    range_maximum <= range_maximum_next;
  end

  // Sequencer: clear pass, leaf-to-root update, query walk from both range ends, empty-range reply
  always_comb begin
    st_next            = st;
    clr_cnt_next       = clr_cnt;
    k_next             = k;
    cur_next           = cur;
    l_next             = l;
    r_next             = r;
    best_next          = best;
    done_next          = 1'b0;
    range_maximum_next = range_maximum;
    pop                = 1'b0;
    wr_en              = 1'b0;
    wr_addr            = clr_cnt;
    wr_data            = LOWEST_VALUE;
    rd_en              = 1'b0;
    rd_addr            = k ^ NODE_W'(1);
    unique case (st)
      ST_CLEAR: begin
        wr_en        = 1'b1;
        clr_cnt_next = clr_cnt + NODE_W'(1);
        if (clr_cnt == NODE_LAST) st_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (status.valid) begin
          pop = 1'b1;
          unique case (head.kind)
            KIND_UPDATE: begin
              wr_en    = 1'b1;
              wr_addr  = {1'b1, head.position};
              wr_data  = head.value;
              k_next   = {1'b1, head.position};
              cur_next = head.value;
              st_next  = ST_U_RD;
            end
            KIND_QUERY: begin
              l_next    = head.l;
              r_next    = head.r;
              best_next = LOWEST_VALUE;
              st_next   = ST_Q_TEST;
            end
            default: begin
              done_next          = 1'b1;
              range_maximum_next = LOWEST_VALUE;
            end
          endcase
        end
      end
      ST_U_RD: begin
        if (k == NODE_ROOT) begin
          st_next = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          st_next = ST_U_WR;
        end
      end
      ST_U_WR: begin
        wr_en    = 1'b1;
        wr_addr  = k >> 1;
        wr_data  = (rd_data > cur) ? rd_data : cur;
        cur_next = wr_data;
        k_next   = k >> 1;
        st_next  = ST_U_RD;
      end
      ST_Q_TEST: begin
        if (l >= r) begin
          done_next          = 1'b1;
          range_maximum_next = best;
          st_next            = ST_IDLE;
        end else if (l[0]) begin
          rd_en   = 1'b1;
          rd_addr = l[NODE_W-1:0];
          st_next = ST_Q_L;
        end else if (r[0]) begin
          rd_en   = 1'b1;
          rd_addr = r_dec[NODE_W-1:0];
          st_next = ST_Q_R;
        end else begin
          l_next = l >> 1;
          r_next = r >> 1;
        end
      end
      ST_Q_L: begin
        best_next = (rd_data > best) ? rd_data : best;
        if (r[0]) begin
          l_next  = l + IDX_W'(1);
          rd_en   = 1'b1;
          rd_addr = r_dec[NODE_W-1:0];
          st_next = ST_Q_R;
        end else begin
          l_next  = (l + IDX_W'(1)) >> 1;
          r_next  = r >> 1;
          st_next = ST_Q_TEST;
        end
      end
      ST_Q_R: begin
        best_next = (rd_data > best) ? rd_data : best;
        l_next    = l >> 1;
        r_next    = r_dec >> 1;
        st_next   = ST_Q_TEST;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  `RMST_ASSERT_IMPL(a_no_pop_clear, st == ST_CLEAR, !pop)
  `RMST_ASSERT_IMPL(a_uwr_not_root, st == ST_U_WR, k > NODE_ROOT)
  `RMST_ASSERT_IMPL(a_done_in_idle, done, st == ST_IDLE)

endmodule
`default_nettype wire
